// ===== sv/assert_macros.svh =====
// Assertion macros shared by the checker modules of this block.
// Each macro takes a label, a disable condition, an antecedent and a consequent.
// The clock is always the signal named clock in the using module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ITRD_ASSERT_SAME(lbl, rst, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("itrd assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ITRD_ASSERT_NEXT(lbl, rst, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("itrd assertion failed");

`endif

// ===== sv/itrd_pkg.sv =====
// ----------------------------------------------------------------------------
// itrd_pkg
// Types, character codes and elaboration-time helpers for the radix digit
// converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itrd_pkg;

   localparam int RADIX_W = 3;
   localparam int CHAR_W  = 7;

   // Conversion modes carried by the radix_code field.
   typedef enum logic [RADIX_W-1:0] {
      RADIX_BIN      = 3'd0,
      RADIX_OCT      = 3'd1,
      RADIX_DEC_SIGN = 3'd2,
      RADIX_HEX      = 3'd3,
      RADIX_DEC      = 3'd4
   } radix_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIGN,
      ST_SHIFT,
      ST_DIV,
      ST_PUT
   } state_type;

   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;
   localparam logic [CHAR_W-1:0] CHAR_A     = 7'h41;
   localparam logic [CHAR_W-1:0] DIGIT_TEN  = 7'd10;

   // Maps a digit value to its ASCII character, upper-case letters above nine.
   function automatic logic [CHAR_W-1:0] digit_to_char(input logic [3:0] d);
      logic [CHAR_W-1:0] ch;
      if (d < 4'd10) begin
         ch = CHAR_ZERO + {3'b000, d};
      end else begin
         ch = CHAR_A + {3'b000, d} - DIGIT_TEN;
      end
      return ch;
   endfunction

   // Number of decimal digits in the largest unsigned number of the given width.
   function automatic int dec_digits(input int width);
      logic [63:0] top;
      int          n;
      top = (width >= 64) ? {64{1'b1}} : ((64'd1 << width) - 64'd1);
      n   = 1;
      while (top >= 64'd10) begin
         top = top / 64'd10;
         n++;
      end
      return n;
   endfunction

   // Ten to the power k; evaluated only at elaboration.
   function automatic logic [63:0] pow10(input int k);
      logic [63:0] p;
      p = 64'd1;
      for (int i = 0; i < k; i++) begin
         p = p * 64'd10;
      end
      return p;
   endfunction

endpackage

`default_nettype wire

// ===== sv/itrd_if.sv =====
// ----------------------------------------------------------------------------
// itrd_if
// Valid/ready channels of the radix digit converter: the request channel that
// carries one value to convert and the response channel that carries one
// character.
// ----------------------------------------------------------------------------
`default_nettype none

interface itrd_req_if #(
   parameter int VALUE_WIDTH = 32
) ();
   logic                          valid;
   logic                          ready;
   logic [VALUE_WIDTH-1:0]        value;
   logic [itrd_pkg::RADIX_W-1:0]  radix_code;
   logic                          is_signed;

   modport source (output valid, output value, output radix_code, output is_signed,
                   input ready);
   modport sink   (input valid, input value, input radix_code, input is_signed,
                   output ready);
endinterface

interface itrd_rsp_if ();
   logic                         valid;
   logic                         ready;
   logic [itrd_pkg::CHAR_W-1:0]  digit_char;
   logic                         last;

   modport source (output valid, output digit_char, output last, input ready);
   modport sink   (input valid, input digit_char, input last, output ready);
endinterface

`default_nettype wire

// ===== sv/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits
// Converts one binary value into fixed-width, zero-padded ASCII digits, most
// significant first, one character per response item.
// ----------------------------------------------------------------------------
// A request item carries a VALUE_WIDTH-bit value, a radix code and a signed
// flag; the block answers with a run of character items, the final one marked
// by last. Binary gives VALUE_WIDTH characters, octal and hex give as many as
// the width needs (11 and 8 at 32 bits, upper-case letters), and in these modes
// the raw bit pattern is printed. Decimal prints as many magnitude digits as
// the largest unsigned value has (10 at 32 bits); the signed-column mode puts
// '0' or '-' in front, and the plain decimal mode drops the sign. Radix codes
// five to seven are accepted and give no characters. The block converts one
// item at a time and holds req ready low until the last character is in the
// output register. Power-of-two radices leave a shift register at one
// character per cycle while the response is not stalled. Decimal digits
// come from one shared compare-and-subtract unit that makes four restoring
// steps per digit against a table of powers of ten. A stalled response
// holds the sequencer once it has a character to deliver, without losing
// anything.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_to_radix_digits #(
   parameter int VALUE_WIDTH = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   itrd_req_if.sink     req_ch,
   itrd_rsp_if.source   rsp_ch
);

   // Digit counts of each mode.
   localparam int DEC_N = itrd_pkg::dec_digits(VALUE_WIDTH);
   localparam int OCT_N = (VALUE_WIDTH + 2) / 3;
   localparam int HEX_N = (VALUE_WIDTH + 3) / 4;

   // The shift register has room for the widest padded pattern (hex or octal).
   localparam int SH_W      = VALUE_WIDTH + 3;
   localparam int BIN_ALIGN = SH_W - VALUE_WIDTH;
   localparam int OCT_ALIGN = SH_W - 3 * OCT_N;
   localparam int HEX_ALIGN = SH_W - 4 * HEX_N;

   localparam int CNT_W = $clog2(VALUE_WIDTH + 1);
   localparam int IDX_W = $clog2(DEC_N);
   localparam int TRY_W = VALUE_WIDTH + 4;

   // Sequencer and datapath registers.
   itrd_pkg::state_type              state_ff, state_in;
   itrd_pkg::radix_type              mode_ff, mode_in;
   logic [SH_W-1:0]                  shreg_ff, shreg_in;
   logic [VALUE_WIDTH-1:0]           rem_ff, rem_in;
   logic [CNT_W-1:0]                 cnt_ff, cnt_in;
   logic [1:0]                       step_ff, step_in;
   logic [3:0]                       quo_ff, quo_in;
   logic                             neg_ff, neg_in;

   // Output register; it decouples the sequencer from the response channel.
   logic                             out_valid_ff, out_valid_in;
   logic [itrd_pkg::CHAR_W-1:0]      out_char_ff, out_char_in;
   logic                             out_last_ff, out_last_in;

   // Powers of ten, one entry per decimal digit position.
   logic [VALUE_WIDTH-1:0]           pow_tab [DEC_N];

   for (genvar g = 0; g < DEC_N; g++) begin : g_pow
      assign pow_tab[g] = VALUE_WIDTH'(itrd_pkg::pow10(g));
   end

   logic                             req_accept;
   logic                             req_neg;
   logic [VALUE_WIDTH-1:0]           req_mag;
   logic [SH_W-1:0]                  req_ext;
   logic                             out_free;
   logic [CNT_W-1:0]                 cnt_dec;
   logic [VALUE_WIDTH-1:0]           pow_sel;
   logic [TRY_W-1:0]                 trial;
   logic [TRY_W-1:0]                 rem_ext;
   logic [TRY_W-1:0]                 diff;
   logic                             take;
   logic [3:0]                       quo_next;
   logic [3:0]                       shift_digit;
   logic                             is_final;

   assign req_ch.ready  = (state_ff == itrd_pkg::ST_IDLE);
   assign req_accept    = req_ch.valid && req_ch.ready;

   // Decimal modes print the magnitude; negation wraps correctly for the
   // most negative value, which reads back as an unsigned power of two.
   assign req_neg = req_ch.is_signed && req_ch.value[VALUE_WIDTH-1];
   assign req_mag = req_neg ? (~req_ch.value + VALUE_WIDTH'(1)) : req_ch.value;
   assign req_ext = {3'b000, req_ch.value};

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign cnt_dec  = cnt_ff - CNT_W'(1);
   assign is_final = (cnt_ff == CNT_W'(1));

   // Shared restoring step: compare the remainder with pow * 2^step.
   assign pow_sel  = pow_tab[cnt_dec[IDX_W-1:0]];
   assign trial    = {4'b0000, pow_sel} << step_ff;
   assign rem_ext  = {4'b0000, rem_ff};
   assign take     = (rem_ext >= trial);
   assign diff     = rem_ext - trial;
   assign quo_next = quo_ff | (take ? (4'b0001 << step_ff) : 4'b0000);

   // Leading digit of the shift register in the latched mode.
   always_comb begin
      priority if (mode_ff == itrd_pkg::RADIX_BIN) begin
         shift_digit = {3'b000, shreg_ff[SH_W-1]};
      end else if (mode_ff == itrd_pkg::RADIX_OCT) begin
         shift_digit = {1'b0, shreg_ff[SH_W-1 -: 3]};
      end else begin
         shift_digit = shreg_ff[SH_W-1 -: 4];
      end
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      shreg_in     = shreg_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      step_in      = step_ff;
      quo_in       = quo_ff;
      neg_in       = neg_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      unique case (state_ff)
         itrd_pkg::ST_IDLE: begin
            if (req_accept) begin
               mode_in = itrd_pkg::radix_type'(req_ch.radix_code);
               neg_in  = req_neg;
               rem_in  = req_mag;
               step_in = 2'd3;
               quo_in  = 4'b0000;
               unique case (req_ch.radix_code)
                  itrd_pkg::RADIX_BIN: begin
                     shreg_in = req_ext << BIN_ALIGN;
                     cnt_in   = CNT_W'(VALUE_WIDTH);
                     state_in = itrd_pkg::ST_SHIFT;
                  end
                  itrd_pkg::RADIX_OCT: begin
                     shreg_in = req_ext << OCT_ALIGN;
                     cnt_in   = CNT_W'(OCT_N);
                     state_in = itrd_pkg::ST_SHIFT;
                  end
                  itrd_pkg::RADIX_HEX: begin
                     shreg_in = req_ext << HEX_ALIGN;
                     cnt_in   = CNT_W'(HEX_N);
                     state_in = itrd_pkg::ST_SHIFT;
                  end
                  itrd_pkg::RADIX_DEC_SIGN: begin
                     cnt_in   = CNT_W'(DEC_N);
                     state_in = itrd_pkg::ST_SIGN;
                  end
                  itrd_pkg::RADIX_DEC: begin
                     cnt_in   = CNT_W'(DEC_N);
                     state_in = itrd_pkg::ST_DIV;
                  end
                  default: begin
                     state_in = itrd_pkg::ST_IDLE;
                  end
               endcase
            end
         end

         itrd_pkg::ST_SIGN: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = neg_ff ? itrd_pkg::CHAR_MINUS : itrd_pkg::CHAR_ZERO;
               out_last_in  = 1'b0;
               state_in     = itrd_pkg::ST_DIV;
            end
         end

         itrd_pkg::ST_SHIFT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itrd_pkg::digit_to_char(shift_digit);
               out_last_in  = is_final;
               cnt_in       = cnt_dec;
               priority if (mode_ff == itrd_pkg::RADIX_BIN) begin
                  shreg_in = shreg_ff << 1;
               end else if (mode_ff == itrd_pkg::RADIX_OCT) begin
                  shreg_in = shreg_ff << 3;
               end else begin
                  shreg_in = shreg_ff << 4;
               end
               if (is_final) begin
                  state_in = itrd_pkg::ST_IDLE;
               end
            end
         end

         itrd_pkg::ST_DIV: begin
            rem_in = take ? diff[VALUE_WIDTH-1:0] : rem_ff;
            quo_in = quo_next;
            if (step_ff != 2'd0) begin
               step_in = step_ff - 2'd1;
            end else if (out_free) begin
               // The last step of a digit goes straight to the output.
               out_valid_in = 1'b1;
               out_char_in  = itrd_pkg::digit_to_char(quo_next);
               out_last_in  = is_final;
               cnt_in       = cnt_dec;
               quo_in       = 4'b0000;
               step_in      = 2'd3;
               state_in     = is_final ? itrd_pkg::ST_IDLE : itrd_pkg::ST_DIV;
            end else begin
               state_in = itrd_pkg::ST_PUT;
            end
         end

         itrd_pkg::ST_PUT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = itrd_pkg::digit_to_char(quo_ff);
               out_last_in  = is_final;
               cnt_in       = cnt_dec;
               quo_in       = 4'b0000;
               step_in      = 2'd3;
               state_in     = is_final ? itrd_pkg::ST_IDLE : itrd_pkg::ST_DIV;
            end
         end

         default: begin
            state_in = itrd_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= itrd_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         step_ff      <= 2'd3;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
         cnt_ff       <= cnt_in;
         step_ff      <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff     <= mode_in;
      shreg_ff    <= shreg_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      neg_ff      <= neg_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.digit_char = out_char_ff;
   assign rsp_ch.last       = out_last_ff;

endmodule

`default_nettype wire

// ===== sv/itrd_checker.sv =====
// ----------------------------------------------------------------------------
// itrd_checker
// Port-level checks of the radix digit converter, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module itrd_checker (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic [itrd_pkg::RADIX_W-1:0]  req_radix_code,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [itrd_pkg::CHAR_W-1:0]   rsp_digit_char,
   input wire logic                          rsp_last
);

   logic req_known;

   assign req_known = (req_radix_code == itrd_pkg::RADIX_BIN)
                   || (req_radix_code == itrd_pkg::RADIX_OCT)
                   || (req_radix_code == itrd_pkg::RADIX_DEC_SIGN)
                   || (req_radix_code == itrd_pkg::RADIX_HEX)
                   || (req_radix_code == itrd_pkg::RADIX_DEC);

   // Reset leaves the block idle with nothing to deliver.
   `ITRD_ASSERT_NEXT(a_reset_idle, 1'b0, reset, !rsp_valid && req_ready)

   // A conversion in a known mode keeps the block busy afterwards.
   `ITRD_ASSERT_NEXT(a_busy_after_req, reset, req_valid && req_ready && req_known, !req_ready)

   // While a character that is not the final one is shown, the conversion is still running.
   `ITRD_ASSERT_SAME(a_busy_mid_run, reset, rsp_valid && !rsp_last, !req_ready)

   // A stalled item holds its contents.
   `ITRD_ASSERT_NEXT(a_rsp_hold, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_digit_char) && $stable(rsp_last))

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_radix_code (req_ch.radix_code),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_digit_char (rsp_ch.digit_char),
   .rsp_last       (rsp_ch.last)
);

`default_nettype wire
